// ===== sv/scp_pkg.sv =====
// Shared types, character codes and a helper function for the serial escape command parser.
package scp_pkg;

  // Operating modes as carried on the mode input.
  localparam logic [1:0] MODE_SELECT     = 2'd0;
  localparam logic [1:0] MODE_SEQUENCING = 2'd1;
  localparam logic [1:0] MODE_TEST       = 2'd2;

  // Characters recognized by the parsers.
  localparam logic [7:0] CH_ESC  = 8'h5C;
  localparam logic [7:0] CH_S    = 8'h73;
  localparam logic [7:0] CH_T    = 8'h74;
  localparam logic [7:0] CH_I    = 8'h69;
  localparam logic [7:0] CH_Y    = 8'h79;
  localparam logic [7:0] CH_E    = 8'h65;
  localparam logic [7:0] CH_P    = 8'h70;
  localparam logic [7:0] CH_N    = 8'h6E;
  localparam logic [7:0] CH_D    = 8'h64;
  localparam logic [7:0] CH_U    = 8'h75;
  localparam logic [7:0] CH_ZERO = 8'h30;
  localparam logic [7:0] CH_A    = 8'h61;

  // Response codes.
  typedef enum logic [1:0] {
    RESP_NONE = 2'd0,
    RESP_ACK  = 2'd1,
    RESP_NACK = 2'd2
  } resp_t;

  // Action codes.
  typedef enum logic [3:0] {
    ACT_NONE       = 4'd0,
    ACT_START_SEQ  = 4'd1,
    ACT_ENTER_TEST = 4'd2,
    ACT_SET_INDEX  = 4'd3,
    ACT_REPLAY     = 4'd4,
    ACT_EXIT_SEQ   = 4'd5,
    ACT_PAUSE      = 4'd6,
    ACT_STEP       = 4'd7,
    ACT_EXIT_TEST  = 4'd8
  } action_t;

  // Select mode parser states.
  typedef enum logic [2:0] {
    SEL_START = 3'd0,
    SEL_ESC   = 3'd1,
    SEL_ID    = 3'd2,
    SEL_SYNC  = 3'd3,
    SEL_PAY1  = 3'd4,
    SEL_PAY2  = 3'd5
  } sel_state_t;

  // Sequencing mode parser states.
  typedef enum logic [1:0] {
    SEQ_START = 2'd0,
    SEQ_ESC   = 2'd1,
    SEQ_ID    = 2'd2,
    SEQ_SYNC  = 2'd3
  } seq_state_t;

  // Test mode parser states.
  typedef enum logic [1:0] {
    TST_START = 2'd0,
    TST_ESC   = 2'd1,
    TST_ID    = 2'd2
  } tst_state_t;

  // Value of a lowercase hex digit; bit 4 set means the byte is not a digit.
  function automatic logic [4:0] hex_value(input logic [7:0] c);
    logic [7:0] diff_num;
    logic [7:0] diff_alpha;
    diff_num   = c - CH_ZERO;
    diff_alpha = c - CH_A + 8'd10;
    if (c >= CH_ZERO && c <= CH_ZERO + 8'd9) begin
      return diff_num[4:0];
    end else if (c >= CH_A && c <= CH_A + 8'd5) begin
      return diff_alpha[4:0];
    end else begin
      return 5'd16;
    end
  endfunction

endpackage

// ===== sv/serial_escape_command_parser_unit.sv =====
// Serial escape command parser: per-mode parsers between an input register and a result register.
//
//  channel | handshake           | payload
//  --------+---------------------+---------------------------------------
//  input   | in_valid / in_stall | rx_byte[7:0], current_mode[1:0]
//  output  | out_valid/out_stall | response[1:0], action[3:0], index_value[7:0]
//
// Every received word gives exactly one result word, which passes from the input register
// into the result register and is held there until it is taken.
// A new word is accepted every cycle while in_stall is low; the parser state update is
// combinational logic between the input register and the result register.
// Synchronous active-high reset returns all three parsers to their start state, clears the
// stored first payload character and empties both registers.
// While the result word is stalled, the input register holds one more word, then the input
// stalls too. The input stall follows the output stall combinationally.
module serial_escape_command_parser_unit (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] rx_byte,
  input  logic [1:0] current_mode,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [1:0] response,
  output logic [3:0] action,
  output logic [7:0] index_value
);

  // Input register.
  logic       in_full;
  logic [7:0] in_byte;
  logic [1:0] in_mode;

  // Parser state.
  scp_pkg::sel_state_t sel_state;
  scp_pkg::sel_state_t sel_next;
  scp_pkg::seq_state_t seq_state;
  scp_pkg::seq_state_t seq_next;
  scp_pkg::tst_state_t tst_state;
  scp_pkg::tst_state_t tst_next;
  logic [7:0]          first_hex_char;
  logic [7:0]          first_hex_char_next;

  // Result of the word in the input register.
  scp_pkg::resp_t   resp_c;
  scp_pkg::action_t act_c;
  logic [7:0]       idx_c;
  logic [4:0]       hi_val;
  logic [4:0]       lo_val;

  logic advance;
  logic accept_in;

  // The input word moves on when the result register is empty or being drained.
  assign advance   = in_full && (!out_valid || !out_stall);
  assign in_stall  = in_full && !advance;
  assign accept_in = in_valid && !in_stall;

  // Input register: valid flag is control, payload loads on acceptance.
  always_ff @(posedge clk) begin
    if (rst) begin
      in_full <= 1'b0;
    end else if (!in_full || advance) begin
      in_full <= in_valid;
    end
    if (accept_in) begin
      in_byte <= rx_byte;
      in_mode <= current_mode;
    end
  end

  // Parser state registers; they only move when a word is processed.
  always_ff @(posedge clk) begin
    if (rst) begin
      sel_state      <= scp_pkg::SEL_START;
      seq_state      <= scp_pkg::SEQ_START;
      tst_state      <= scp_pkg::TST_START;
      first_hex_char <= 8'd0;
    end else if (advance) begin
      sel_state      <= sel_next;
      seq_state      <= seq_next;
      tst_state      <= tst_next;
      first_hex_char <= first_hex_char_next;
    end
  end

  // Next state and result for the word in the input register.
  always_comb begin
    sel_next            = sel_state;
    seq_next            = seq_state;
    tst_next            = tst_state;
    first_hex_char_next = first_hex_char;
    resp_c              = scp_pkg::RESP_NONE;
    act_c               = scp_pkg::ACT_NONE;
    idx_c               = 8'd0;
    hi_val              = scp_pkg::hex_value(first_hex_char);
    lo_val              = scp_pkg::hex_value(in_byte);

    case (in_mode)
      scp_pkg::MODE_SELECT: begin
        case (sel_state)
          scp_pkg::SEL_START: begin
            if (in_byte == scp_pkg::CH_ESC) begin
              sel_next = scp_pkg::SEL_ESC;
            end
          end
          scp_pkg::SEL_ESC: begin
            sel_next = (in_byte == scp_pkg::CH_ESC) ? scp_pkg::SEL_ID : scp_pkg::SEL_START;
          end
          scp_pkg::SEL_ID: begin
            sel_next = scp_pkg::SEL_START;
            case (in_byte)
              scp_pkg::CH_S: begin
                resp_c = scp_pkg::RESP_ACK;
                act_c  = scp_pkg::ACT_START_SEQ;
              end
              scp_pkg::CH_T: begin
                resp_c = scp_pkg::RESP_ACK;
                act_c  = scp_pkg::ACT_ENTER_TEST;
              end
              scp_pkg::CH_I: begin
                sel_next = scp_pkg::SEL_PAY1;
              end
              scp_pkg::CH_Y: begin
                // Sync request returns to start without a response.
                sel_next = scp_pkg::SEL_START;
              end
              default: begin
                resp_c = scp_pkg::RESP_NACK;
              end
            endcase
          end
          scp_pkg::SEL_PAY1: begin
            first_hex_char_next = in_byte;
            sel_next            = scp_pkg::SEL_PAY2;
          end
          scp_pkg::SEL_PAY2: begin
            sel_next = scp_pkg::SEL_START;
            if (hi_val[4] || lo_val[4]) begin
              resp_c = scp_pkg::RESP_NACK;
            end else begin
              resp_c = scp_pkg::RESP_ACK;
              act_c  = scp_pkg::ACT_SET_INDEX;
              idx_c  = {hi_val[3:0], lo_val[3:0]};
            end
          end
          default: begin
            sel_next = scp_pkg::SEL_START;
          end
        endcase
      end

      scp_pkg::MODE_SEQUENCING: begin
        case (seq_state)
          scp_pkg::SEQ_START: begin
            if (in_byte == scp_pkg::CH_ESC) begin
              seq_next = scp_pkg::SEQ_ESC;
            end
          end
          scp_pkg::SEQ_ESC: begin
            seq_next = (in_byte == scp_pkg::CH_ESC) ? scp_pkg::SEQ_ID : scp_pkg::SEQ_START;
          end
          scp_pkg::SEQ_ID: begin
            seq_next = scp_pkg::SEQ_START;
            resp_c   = scp_pkg::RESP_ACK;
            case (in_byte)
              scp_pkg::CH_S: act_c = scp_pkg::ACT_REPLAY;
              scp_pkg::CH_E: act_c = scp_pkg::ACT_EXIT_SEQ;
              scp_pkg::CH_P: act_c = scp_pkg::ACT_PAUSE;
              scp_pkg::CH_N: act_c = scp_pkg::ACT_STEP;
              default:       resp_c = scp_pkg::RESP_NACK;
            endcase
          end
          default: begin
            seq_next = scp_pkg::SEQ_START;
          end
        endcase
      end

      scp_pkg::MODE_TEST: begin
        case (tst_state)
          scp_pkg::TST_START: begin
            if (in_byte == scp_pkg::CH_ESC) begin
              tst_next = scp_pkg::TST_ESC;
            end
          end
          scp_pkg::TST_ESC: begin
            tst_next = (in_byte == scp_pkg::CH_ESC) ? scp_pkg::TST_ID : scp_pkg::TST_START;
          end
          scp_pkg::TST_ID: begin
            tst_next = scp_pkg::TST_START;
            resp_c   = scp_pkg::RESP_ACK;
            case (in_byte)
              scp_pkg::CH_D: act_c = scp_pkg::ACT_NONE;
              scp_pkg::CH_U: act_c = scp_pkg::ACT_NONE;
              scp_pkg::CH_E: act_c = scp_pkg::ACT_EXIT_TEST;
              default:       resp_c = scp_pkg::RESP_NACK;
            endcase
          end
          default: begin
            tst_next = scp_pkg::TST_START;
          end
        endcase
      end

      default: begin
        // The fourth mode code is ignored: no response and no state change.
        resp_c = scp_pkg::RESP_NONE;
      end
    endcase
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
    if (advance) begin
      response    <= resp_c;
      action      <= act_c;
      index_value <= idx_c;
    end
  end

endmodule

// ===== sv/scp_checker.sv =====
// Port-level checker for the serial escape command parser and its bind to the top level.
module scp_checker (
  input logic       clk,
  input logic       rst,
  input logic       out_valid,
  input logic       out_stall,
  input logic [1:0] response,
  input logic [3:0] action,
  input logic [7:0] index_value
);

  // A stalled result word keeps its contents.
  assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(response) && $stable(action)
      && $stable(index_value))
  else $error("stalled result word changed");

  // Any action comes with an acknowledge.
  assert property (@(posedge clk) disable iff (rst)
    out_valid && action != scp_pkg::ACT_NONE |-> response == scp_pkg::RESP_ACK)
  else $error("action without acknowledge");

  // The index is only reported with a set-index action.
  assert property (@(posedge clk) disable iff (rst)
    out_valid && action != scp_pkg::ACT_SET_INDEX |-> index_value == 8'd0)
  else $error("index value outside set-index action");

  // No result word right after reset.
  assert property (@(posedge clk) $past(rst) |-> !out_valid)
  else $error("result word valid after reset");

endmodule

bind serial_escape_command_parser_unit scp_checker u_scp_checker (.*);
